// ----- rtl/tun_pkg.sv -----
// Package with the shared constants of the triangle unit normal core.
package tun_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int NORMAL_WIDTH_DEF = 16;
    localparam int LANES            = 3;
    localparam int VERTS            = 9;

endpackage

// ----- rtl/tun_front.sv -----
// Edge vectors, cross product, component squares and their sum, in five stages.
module tun_front #(
    parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic [8:0][COORD_WIDTH-1:0]           coord,
    output logic                                  out_vld,
    output logic                                  out_deg,
    output logic [2:0]                            out_sign,
    output logic [2:0][2*((COORD_WIDTH > 16 ? 16 : COORD_WIDTH) + 1)-1:0] out_mag,
    output logic [4*((COORD_WIDTH > 16 ? 16 : COORD_WIDTH) + 1)+1:0]      out_sum
);
    import tun_pkg::*;

    localparam int EW = (COORD_WIDTH > 16 ? 16 : COORD_WIDTH) + 1;
    localparam int SH = COORD_WIDTH > 16 ? COORD_WIDTH - 16 : 0;
    localparam int CM = 2 * EW;
    localparam int SW = 2 * CM + 2;

    logic [4:0]                vld_reg;
    logic signed [EW-1:0]      u_reg [LANES];
    logic signed [EW-1:0]      v_reg [LANES];
    logic signed [2*EW-1:0]    p_reg [6];
    logic [2:0]                sign3_reg, sign4_reg, sign5_reg;
    logic [CM-1:0]             mag3_reg [LANES];
    logic [CM-1:0]             mag4_reg [LANES];
    logic [CM-1:0]             mag5_reg [LANES];
    logic [2*CM-1:0]           sq_reg [LANES];
    logic [SW-1:0]             sum_reg;
    logic                      deg_reg;
    logic [SW-1:0]             sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    for (genvar e = 0; e < LANES; e++)
    begin : g_edge
        logic signed [COORD_WIDTH:0] du, dv, us, vs;
        logic signed [2*EW:0]        c;
        logic [2*EW:0]               cabs;
        assign du = $signed({coord[6+e][COORD_WIDTH-1], coord[6+e]})
                  - $signed({coord[3+e][COORD_WIDTH-1], coord[3+e]});
        assign dv = $signed({coord[e][COORD_WIDTH-1], coord[e]})
                  - $signed({coord[3+e][COORD_WIDTH-1], coord[3+e]});
        assign us = du >>> SH;
        assign vs = dv >>> SH;
        assign c  = $signed({p_reg[2*e][2*EW-1], p_reg[2*e]})
                  - $signed({p_reg[2*e+1][2*EW-1], p_reg[2*e+1]});
        assign cabs = c[2*EW] ? (~c + 1'b1) : c;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_reg[e]    <= us[EW-1:0];
                v_reg[e]    <= vs[EW-1:0];
                sign3_reg[e] <= c[2*EW];
                mag3_reg[e] <= cabs[CM-1:0];
                sq_reg[e]   <= mag3_reg[e] * mag3_reg[e];
                mag4_reg[e] <= mag3_reg[e];
                mag5_reg[e] <= mag4_reg[e];
            end
        end
    end

    // Cross product terms: x = uy*vz - uz*vy, y = uz*vx - ux*vz, z = ux*vy - uy*vx.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= u_reg[1] * v_reg[2];
            p_reg[1]  <= u_reg[2] * v_reg[1];
            p_reg[2]  <= u_reg[2] * v_reg[0];
            p_reg[3]  <= u_reg[0] * v_reg[2];
            p_reg[4]  <= u_reg[0] * v_reg[1];
            p_reg[5]  <= u_reg[1] * v_reg[0];
            sign4_reg <= sign3_reg;
            sign5_reg <= sign4_reg;
            sum_reg   <= sum_next;
            deg_reg   <= (sum_next == '0);
        end
    end

    assign sum_next = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    assign out_vld  = vld_reg[4];
    assign out_deg  = deg_reg;
    assign out_sign = sign5_reg;
    assign out_sum  = sum_reg;
    for (genvar k = 0; k < LANES; k++)
    begin : g_out
        assign out_mag[k] = mag5_reg[k];
    end

endmodule

// ----- rtl/tun_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with a side payload.
module tun_sqrt #(
    parameter int RB = 35,
    parameter int PW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [2*RB-1:0] in_s,
    input  logic [PW-1:0]   in_pay,
    output logic            out_vld,
    output logic [RB-1:0]   out_root,
    output logic [PW-1:0]   out_pay
);
    import tun_pkg::*;

    localparam int SW = 2 * RB;
    localparam int RW = RB + 3;

    logic [RB-1:0]  vld_reg;
    logic [RW-1:0]  rem_reg  [RB];
    logic [RB-1:0]  root_reg [RB];
    logic [SW-1:0]  s_reg    [RB];
    logic [PW-1:0]  pay_reg  [RB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RB-2:0], in_vld};
        end
    end

    for (genvar k = 0; k < RB; k++)
    begin : g_stage
        logic [RW-1:0] rem_p, rem_t, trial;
        logic [RB-1:0] root_p;
        logic [SW-1:0] s_p;
        logic [PW-1:0] pay_p;
        if (k == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign s_p    = in_s;
            assign pay_p  = in_pay;
        end
        else
        begin : g_rest
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign s_p    = s_reg[k-1];
            assign pay_p  = pay_reg[k-1];
        end
        assign rem_t = {rem_p[RB:0], s_p[SW-1:SW-2]};
        assign trial = {1'b0, root_p, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_t >= trial)
                begin
                    rem_reg[k]  <= rem_t - trial;
                    root_reg[k] <= {root_p[RB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_t;
                    root_reg[k] <= {root_p[RB-2:0], 1'b0};
                end
                s_reg[k]   <= {s_p[SW-3:0], 2'b00};
                pay_reg[k] <= pay_p;
            end
        end
    end

    assign out_vld  = vld_reg[RB-1];
    assign out_root = root_reg[RB-1];
    assign out_pay  = pay_reg[RB-1];

endmodule

// ----- rtl/tun_div.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage.
module tun_div #(
    parameter int CM = 34,
    parameter int RB = 35,
    parameter int F  = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [RB-1:0]        in_len,
    input  logic [2:0][CM-1:0]   in_mag,
    input  logic [2:0]           in_sign,
    input  logic                 in_deg,
    output logic                 out_vld,
    output logic [2:0][F:0]      out_q,
    output logic [2:0]           out_sign,
    output logic                 out_deg
);
    import tun_pkg::*;

    localparam int NS = F + 1;

    logic [NS-1:0]      vld_reg;
    logic [RB-1:0]      len_reg  [NS];
    logic [2:0]         sign_reg [NS];
    logic               deg_reg  [NS];
    logic [2:0][RB:0]   rem_reg  [NS];
    logic [2:0][F:0]    q_reg    [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        logic [RB-1:0] len_p;
        logic [2:0]    sign_p;
        logic          deg_p;
        if (j == 0)
        begin : g_first
            assign len_p  = in_len;
            assign sign_p = in_sign;
            assign deg_p  = in_deg;
        end
        else
        begin : g_rest
            assign len_p  = len_reg[j-1];
            assign sign_p = sign_reg[j-1];
            assign deg_p  = deg_reg[j-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [RB:0] r_t;
            logic [F:0]  q_p;
            logic        qbit;
            if (j == 0)
            begin : g_first
                assign r_t = {{(RB+1-CM){1'b0}}, in_mag[l]};
                assign q_p = '0;
            end
            else
            begin : g_rest
                assign r_t = {rem_reg[j-1][l][RB-1:0], 1'b0};
                assign q_p = q_reg[j-1][l];
            end
            assign qbit = (r_t >= {1'b0, len_p});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j][l] <= qbit ? (r_t - {1'b0, len_p}) : r_t;
                    q_reg[j][l]   <= {q_p[F-1:0], qbit};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[j]  <= len_p;
                sign_reg[j] <= sign_p;
                deg_reg[j]  <= deg_p;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_q    = q_reg[NS-1];
    assign out_sign = sign_reg[NS-1];
    assign out_deg  = deg_reg[NS-1];

endmodule

// ----- rtl/triangle_unit_normal_core.sv -----
// The pipeline is 5 front stages, one square root stage per root bit, one divider
// stage per quotient bit and the output register. Throughput is one triangle per
// cycle while the output is not stalled.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data needs none.
// Top level: unit face normal of a triangle given as three vertices.
module triangle_unit_normal_core #(
    parameter int COORD_WIDTH  = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = tun_pkg::NORMAL_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y,
    // third_z, then zero fill up to a whole byte.
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // normal_x, normal_y, normal_z, then zero fill up to a whole byte.
    output logic [((3*NORMAL_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0] m_axis_tuser
);
    import tun_pkg::*;

    localparam int EW  = (COORD_WIDTH > 16 ? 16 : COORD_WIDTH) + 1;
    localparam int CM  = 2 * EW;
    localparam int RB  = CM + 1;
    localparam int F   = NORMAL_WIDTH - 2;
    localparam int PW  = 4 + 3 * CM;
    localparam int OW  = ((3*NORMAL_WIDTH+7)/8)*8;

    // The pipeline advances whenever the output register is empty or being drained,
    // so a transaction is taken on the input in the same cycle one leaves.
    logic adv;

    logic [8:0][COORD_WIDTH-1:0]   coord;
    logic                          fr_vld, fr_deg;
    logic [2:0]                    fr_sign;
    logic [2:0][CM-1:0]            fr_mag;
    logic [2*RB-1:0]               fr_sum;

    logic                          sq_vld;
    logic [RB-1:0]                 sq_root;
    logic [PW-1:0]                 sq_pay;
    logic [2:0][CM-1:0]            sq_mag;

    logic                          dv_vld, dv_deg;
    logic [2:0][F:0]               dv_q;
    logic [2:0]                    dv_sign;

    logic                          out_vld_reg;
    logic [2:0][NORMAL_WIDTH-1:0]  norm_reg, norm_next;
    logic                          deg_reg;

    assign adv = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    for (genvar i = 0; i < VERTS; i++)
    begin : g_unpack
        assign coord[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end

    tun_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s_axis_tvalid),
        .coord    (coord),
        .out_vld  (fr_vld),
        .out_deg  (fr_deg),
        .out_sign (fr_sign),
        .out_mag  (fr_mag),
        .out_sum  (fr_sum)
    );

    // The signs, magnitudes and degenerate flag ride alongside the root.
    tun_sqrt #(
        .RB(RB),
        .PW(PW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (fr_vld),
        .in_s     (fr_sum),
        .in_pay   ({fr_deg, fr_sign, fr_mag}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_pay  (sq_pay)
    );

    assign sq_mag = sq_pay[3*CM-1:0];

    // A degenerate triangle divides by zero here; its quotient is discarded below.
    tun_div #(
        .CM(CM),
        .RB(RB),
        .F (F)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sq_vld),
        .in_len   (sq_root),
        .in_mag   (sq_mag),
        .in_sign  (sq_pay[3*CM +: 3]),
        .in_deg   (sq_pay[PW-1]),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_sign (dv_sign),
        .out_deg  (dv_deg)
    );

    // Apply the sign of each cross product component; the quotient never exceeds
    // one in Q1.F, so it always fits the signed output field.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (dv_deg)
            begin
                norm_next[l] = '0;
            end
            else if (dv_sign[l])
            begin
                norm_next[l] = ~{1'b0, dv_q[l]} + 1'b1;
            end
            else
            begin
                norm_next[l] = {1'b0, dv_q[l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_reg <= norm_next;
            deg_reg  <= dv_deg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OW-3*NORMAL_WIDTH){1'b0}}, norm_reg};
    assign m_axis_tuser  = deg_reg;

endmodule

// ----- rtl/tun_checker.sv -----
// Port-level assertions for the triangle unit normal core, bound to the top level.
module tun_checker #(
    parameter int COORD_WIDTH  = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = tun_pkg::NORMAL_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((3*NORMAL_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser
);
    import tun_pkg::*;

    localparam int F = NORMAL_WIDTH - 2;
    localparam logic signed [NORMAL_WIDTH-1:0] NMAX = NORMAL_WIDTH'(1) <<< F;
    localparam logic signed [NORMAL_WIDTH-1:0] NMIN = -NMAX;

    logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
    assign nx = m_axis_tdata[0 +: NORMAL_WIDTH];
    assign ny = m_axis_tdata[NORMAL_WIDTH +: NORMAL_WIDTH];
    assign nz = m_axis_tdata[2*NORMAL_WIDTH +: NORMAL_WIDTH];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result transaction changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> nx == '0 && ny == '0 && nz == '0)
        else $error("degenerate result with a nonzero normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> nx <= NMAX && nx >= NMIN && ny <= NMAX && ny >= NMIN
            && nz <= NMAX && nz >= NMIN)
        else $error("normal component beyond unit magnitude");

endmodule

bind triangle_unit_normal_core tun_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .NORMAL_WIDTH(NORMAL_WIDTH)
) u_tun_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
